>>> design/lrk_pkg.sv
package lrk_pkg;

    // Input item: load a point or evaluate one kernel entry
    typedef struct packed {
        logic               op;
        logic [11:0]        first_index;
        logic [11:0]        second_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic signed [31:0] kernel_value;
        logic [1:0]         region;
    } out_item_t;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Region codes
    localparam logic [1:0] REGION_ZERO  = 2'd0;
    localparam logic [1:0] REGION_INNER = 2'd1;
    localparam logic [1:0] REGION_OUTER = 2'd2;

    // ln 2 with 32 fraction bits
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Squared radius after reset (radius 1.0 in Q16.16)
    localparam logic [61:0] A2_RESET = 62'h1_0000_0000;

    // Number of log fraction bits, one iteration stage each
    localparam int unsigned ITER_COUNT = 32;

    // State carried through the iteration stages
    typedef struct packed {
        logic [31:0] mant;      // Q1.31 mantissa under repeated squaring
        logic [31:0] frac;      // log2 fraction bits so far
        logic [61:0] rem;       // division remainder
        logic [31:0] quot;      // R2 / radius^2 quotient bits so far
        logic [6:0]  lead;      // integer part of log2 of raw R2
        logic        zero;      // R2 is zero
        logic        inner;     // R2 below radius^2
    } iter_t;

endpackage

>>> design/lrk_ram.sv
module lrk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> design/lrk_front.sv
module lrk_front #(
    parameter int POINT_COUNT = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  lrk_pkg::in_item_t in_item,
    input  logic [61:0]      a2,
    output logic             out_valid,
    input  logic             down_ready,
    output lrk_pkg::iter_t   out_data
);
    import lrk_pkg::*;

    localparam int AW = $clog2(POINT_COUNT);

    logic          rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic          oka_reg, okb_reg, oka, okb, ok_w;
    logic          accept;
    logic [63:0]   rd_a, rd_b;
    logic [AW-1:0] addr_a, addr_b;
    logic signed [31:0] xa, ya, xb, yb;
    logic signed [32:0] ddx, ddy;
    logic [31:0]   dx_next, dy_next, dx_reg, dy_reg;
    logic [63:0]   sx_reg, sy_reg;
    logic [64:0]   r2_reg, r2b_reg, r2_shift;
    logic [6:0]    lead_next, lead_reg;
    logic          zero_reg, inner_reg;
    iter_t         out_next, out_reg;

    // Ready chain: a stage takes new data when empty or when it drains
    assign rdy6     = !v6_reg || down_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;
    assign accept   = in_valid && rdy1;

    // Index range checks and store addresses
    assign oka    = 32'(in_item.first_index) < POINT_COUNT;
    assign okb    = 32'(in_item.second_index) < POINT_COUNT;
    assign ok_w   = oka;
    assign addr_a = AW'(in_item.first_index);
    assign addr_b = AW'(in_item.second_index);

    // Point store, x in the upper half
    lrk_ram #(
        .WIDTH (64),
        .DEPTH (POINT_COUNT)
    ) u_store (
        .clk     (clk),
        .we      (accept && in_item.op == OP_LOAD && ok_w),
        .waddr   (addr_a),
        .wdata   ({in_item.point_x, in_item.point_y}),
        .re      (rdy1),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Valid bits; only evaluations travel down the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid && in_item.op == OP_EVAL;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // Absolute coordinate differences; out-of-range points read as the origin
    always_comb
    begin
        xa  = oka_reg ? rd_a[63:32] : 32'sd0;
        ya  = oka_reg ? rd_a[31:0]  : 32'sd0;
        xb  = okb_reg ? rd_b[63:32] : 32'sd0;
        yb  = okb_reg ? rd_b[31:0]  : 32'sd0;
        ddx = 33'(xa) - 33'(xb);
        ddy = 33'(ya) - 33'(yb);
        dx_next = ddx[32] ? 32'(-ddx) : ddx[31:0];
        dy_next = ddy[32] ? 32'(-ddy) : ddy[31:0];
    end

    // Leading one of R2
    always_comb
    begin
        lead_next = 7'd0;
        for (int i = 0; i < 65; i++)
        begin
            if (r2_reg[i])
            begin
                lead_next = 7'(i);
            end
        end
    end

    // Normalize to Q1.31 mantissa
    assign r2_shift = r2b_reg << (7'd64 - lead_reg);

    always_comb
    begin
        out_next.mant  = r2_shift[64:33];
        out_next.frac  = 32'd0;
        out_next.rem   = r2b_reg[61:0];
        out_next.quot  = 32'd0;
        out_next.lead  = lead_reg;
        out_next.zero  = zero_reg;
        out_next.inner = inner_reg;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            oka_reg <= oka;
            okb_reg <= okb;
        end
        if (rdy2)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (rdy3)
        begin
            sx_reg <= 64'(dx_reg) * 64'(dx_reg);
            sy_reg <= 64'(dy_reg) * 64'(dy_reg);
        end
        if (rdy4)
        begin
            r2_reg <= {1'b0, sx_reg} + {1'b0, sy_reg};
        end
        if (rdy5)
        begin
            r2b_reg   <= r2_reg;
            lead_reg  <= lead_next;
            zero_reg  <= r2_reg == 65'd0;
            inner_reg <= r2_reg < {3'b000, a2};
        end
        if (rdy6)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_data  = out_reg;

endmodule

>>> design/lrk_iter.sv
module lrk_iter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           up_ready,
    input  lrk_pkg::iter_t in_data,
    input  logic [61:0]    a2,
    output logic           out_valid,
    input  logic           down_ready,
    output lrk_pkg::iter_t out_data
);
    import lrk_pkg::*;

    logic        valid_reg;
    iter_t       data_reg, data_next;
    logic [63:0] sq;
    logic [62:0] rem_sh;
    logic        carry, ge;

    assign up_ready = !valid_reg || down_ready;

    // One log2 fraction bit by squaring, one quotient bit by restoring division
    always_comb
    begin
        sq     = 64'(in_data.mant) * 64'(in_data.mant);
        carry  = sq[63];
        rem_sh = {in_data.rem, 1'b0};
        ge     = rem_sh >= {1'b0, a2};
        data_next       = in_data;
        data_next.mant  = carry ? sq[63:32] : sq[62:31];
        data_next.frac  = {in_data.frac[30:0], carry};
        data_next.rem   = ge ? 62'(rem_sh - {1'b0, a2}) : rem_sh[61:0];
        data_next.quot  = {in_data.quot[30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> design/lrk_tail.sv
module lrk_tail (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             up_ready,
    input  lrk_pkg::iter_t   in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output lrk_pkg::out_item_t out_item
);
    import lrk_pkg::*;

    // Flags that ride along with every stage
    typedef struct packed {
        logic zero;
        logic inner;
        logic neg;
    } flag_t;

    logic        rdy1, rdy2, rdy3, rdy4, rdy5;
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    flag_t       f1_next, f1_reg, f2_reg, f3_reg, f4_reg;
    logic [38:0] log_raw, mag_l;
    logic [5:0]  mi_reg;
    logic [31:0] mf_reg;
    logic [31:0] q1_reg, q2_reg, q3_reg;
    logic [63:0] pf_prod, plo_prod;
    logic [31:0] pf_reg, plo_reg;
    logic [37:0] pi_reg, ln_reg, ln4_reg, phi_reg;
    logic [38:0] t_sum;
    logic [31:0] mag_o, val_o;
    out_item_t   out_next, out_reg;

    assign rdy5     = !v5_reg || !out_stall;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign up_ready = rdy1;

    // |log2(R2)|: raw log2 less 32, sign kept apart
    always_comb
    begin
        log_raw       = {in_data.lead, in_data.frac};
        f1_next.zero  = in_data.zero;
        f1_next.inner = in_data.inner;
        f1_next.neg   = in_data.lead < 7'd32;
        mag_l = f1_next.neg ? ({7'd32, 32'd0} - log_raw) : (log_raw - {7'd32, 32'd0});
    end

    // ln magnitude parts and inner products
    assign pf_prod  = 64'(mf_reg) * 64'(LN2_Q32);
    assign plo_prod = 64'(q3_reg) * 64'(ln_reg[31:0]);

    // Final scale; magnitude stays below 2^21, so the Q16.16 result needs no clamp
    always_comb
    begin
        t_sum = 39'(phi_reg) + 39'(plo_reg);
        mag_o = f4_reg.inner ? 32'(t_sum[38:17]) : 32'(ln4_reg[37:17]);
        val_o = f4_reg.neg ? (32'd0 - mag_o) : mag_o;
        if (f4_reg.zero)
        begin
            out_next.kernel_value = 32'sd0;
            out_next.region       = REGION_ZERO;
        end
        else
        begin
            out_next.kernel_value = val_o;
            out_next.region       = f4_reg.inner ? REGION_INNER : REGION_OUTER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            mi_reg <= mag_l[37:32];
            mf_reg <= mag_l[31:0];
            q1_reg <= in_data.quot;
            f1_reg <= f1_next;
        end
        if (rdy2)
        begin
            pf_reg <= pf_prod[63:32];
            pi_reg <= 38'(mi_reg) * 38'(LN2_Q32);
            q2_reg <= q1_reg;
            f2_reg <= f1_reg;
        end
        if (rdy3)
        begin
            ln_reg <= pi_reg + 38'(pf_reg);
            q3_reg <= q2_reg;
            f3_reg <= f2_reg;
        end
        if (rdy4)
        begin
            plo_reg <= plo_prod[63:32];
            phi_reg <= 38'(q3_reg) * 38'(ln_reg[37:32]);
            ln4_reg <= ln_reg;
            f4_reg  <= f3_reg;
        end
        if (rdy5)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_item  = out_reg;

endmodule

>>> design/log_radial_kernel_entry.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   in_item  (load or evaluate)
// out       output     out_valid / out_stall out_item (kernel value, region)
// radius    input      radius_wr_en          radius_wr_data (31-bit Q15.16)
//
// One item per cycle while out is not stalled; an evaluation result passes through
// 43 register stages: 6 front, 32 log/divide iteration, 5 back.
// Loads write the point store at accept and produce no result.
// Reset clears all valid bits and sets radius to 1.0; the store is not cleared.
// A stall on out holds the output register; bubbles ahead of it still fill.
module log_radial_kernel_entry #(
    parameter int POINT_COUNT = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lrk_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output lrk_pkg::out_item_t out_item,
    input  logic               radius_wr_en,
    input  logic [30:0]        radius_wr_data
);
    import lrk_pkg::*;

    logic [61:0] a2_reg;
    iter_t       link_data [ITER_COUNT+1];
    logic        link_valid [ITER_COUNT+1];
    logic        link_ready [ITER_COUNT+1];

    // Squared radius, formed at the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a2_reg <= A2_RESET;
        end
        else if (radius_wr_en)
        begin
            a2_reg <= 62'(radius_wr_data) * 62'(radius_wr_data);
        end
    end

    lrk_front #(
        .POINT_COUNT (POINT_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .a2         (a2_reg),
        .out_valid  (link_valid[0]),
        .down_ready (link_ready[0]),
        .out_data   (link_data[0])
    );

    // Iteration stages, one fraction bit and one quotient bit each
    for (genvar k = 0; k < ITER_COUNT; k++)
    begin : g_iter
        lrk_iter u_iter (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (link_valid[k]),
            .up_ready   (link_ready[k]),
            .in_data    (link_data[k]),
            .a2         (a2_reg),
            .out_valid  (link_valid[k+1]),
            .down_ready (link_ready[k+1]),
            .out_data   (link_data[k+1])
        );
    end

    lrk_tail u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[ITER_COUNT]),
        .up_ready  (link_ready[ITER_COUNT]),
        .in_data   (link_data[ITER_COUNT]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

>>> design/lrk_check.sv
module lrk_check (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input lrk_pkg::out_item_t out_item
);
    import lrk_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // Input back-pressure only comes from a held result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free output");

    // Region code is one of the three defined
    a_region: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.region == REGION_ZERO || out_item.region == REGION_INNER
                       || out_item.region == REGION_OUTER))
        else $error("bad region code");

    // Coincident points give zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.region == REGION_ZERO |-> out_item.kernel_value == 32'sd0)
        else $error("nonzero value for coincident points");

endmodule

bind log_radial_kernel_entry lrk_check u_lrk_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
